FILE: sv/coulomb_count_charge_estimator_top_defines.svh
// Assertion macros shared by the estimator RTL.
`ifndef COULOMB_COUNT_CHARGE_ESTIMATOR_TOP_DEFINES_SVH
`define COULOMB_COUNT_CHARGE_ESTIMATOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define CCCE_ASSERT_NOW(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define CCCE_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

FILE: sv/ccce_pkg.sv
package ccce_pkg;

  localparam int VOLT_W = 20;
  localparam int CHG_W = 40;
  localparam int SOC_W = 15;
  localparam int ANCHOR_NUM_W = VOLT_W + SOC_W;
  localparam int NUM_W = CHG_W + SOC_W;
  localparam int CNT_W = 6;

  localparam logic [SOC_W-1:0] SOC_FULL = SOC_W'(25600);
  localparam logic [CNT_W-1:0] ANCHOR_ITERS = CNT_W'(ANCHOR_NUM_W);
  localparam logic [CNT_W-1:0] COUNT_ITERS = CNT_W'(NUM_W);

  localparam logic [VOLT_W-1:0] FULL_RESET = VOLT_W'(64512);
  localparam logic [VOLT_W-1:0] EMPTY_RESET = VOLT_W'(46080);
  localparam logic [CHG_W-1:0] CAP_RESET = CHG_W'(1000000);

  typedef enum logic [1:0] {
    SRC_FULL,
    SRC_EMPTY,
    SRC_COUNTED,
    SRC_CLAMPED
  } source_t;

  typedef enum logic [1:0] {
    CFG_FULL,
    CFG_EMPTY,
    CFG_CAP
  } cfg_index_t;

  typedef struct packed {
    logic        op;
    logic [23:0] bus_raw;
    logic [39:0] charge_raw;
  } in_item_t;

  typedef struct packed {
    logic [SOC_W-1:0] soc_level;
    source_t          source;
    logic             anchored_now;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ANCHOR,
    ST_COUNT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic restart;
    logic anchor_go;
    logic anchor_set;
    logic count_go;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic op_restart;
    logic anchored;
    logic extreme;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

FILE: sv/ccce_ctrl.sv
module ccce_ctrl
  import ccce_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.op_restart) begin
          cmd.restart = 1'b1;
          state_next = ST_EMIT;
        end else if (!status.anchored) begin
          cmd.anchor_go = 1'b1;
          state_next = ST_ANCHOR;
        end else if (status.extreme) begin
          state_next = ST_EMIT;
        end else begin
          cmd.count_go = 1'b1;
          state_next = ST_COUNT;
        end
      end
      ST_ANCHOR: begin
        if (status.div_done) begin
          cmd.anchor_set = 1'b1;
          if (status.extreme) begin
            state_next = ST_EMIT;
          end else begin
            cmd.count_go = 1'b1;
            state_next = ST_COUNT;
          end
        end
      end
      ST_COUNT: begin
        if (status.div_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

FILE: sv/ccce_div.sv
`include "coulomb_count_charge_estimator_top_defines.svh"

module ccce_div
  import ccce_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [CHG_W-1:0] divisor,
  input  logic [CNT_W-1:0] iters,
  output logic [NUM_W-1:0] quotient,
  output logic             done
);

  logic [CHG_W-1:0] rem;
  logic [CHG_W-1:0] dvs;
  logic [NUM_W-1:0] quo;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [CHG_W:0]   trial;
  logic [CHG_W+1:0] diff;

  assign trial = {rem, quo[NUM_W-1]};
  assign diff = {1'b0, trial} - {2'b00, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= iters;
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      if (!diff[CHG_W+1]) begin
        rem <= diff[CHG_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b1};
      end else begin
        rem <= trial[CHG_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b0};
      end
    end
  end

  `CCCE_ASSERT_NOW(a_start_idle, start, !busy, "divider started while busy")
  `CCCE_ASSERT_NEXT(a_done_pulse, done, !done, "divider done held past one cycle")

endmodule

FILE: sv/ccce_dp.sv
`include "coulomb_count_charge_estimator_top_defines.svh"

module ccce_dp
  import ccce_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [39:0] cfg_data,
  input  cmd_t        cmd,
  output status_t     status
);

  logic [VOLT_W-1:0] full_level;
  logic [VOLT_W-1:0] empty_level;
  logic [CHG_W-1:0]  capacity;
  logic [SOC_W-1:0]  start_level;
  logic              anchored;
  logic              now_flag;
  logic              op_q;
  logic [VOLT_W-1:0] volts;
  logic              neg;
  logic [CHG_W-1:0]  mag;

  logic                    ge_full;
  logic                    le_empty;
  logic                    range_ok;
  logic [VOLT_W-1:0]       range_v;
  logic [VOLT_W-1:0]       c_hi;
  logic [VOLT_W-1:0]       c_lo;
  logic [VOLT_W-1:0]       c_off;
  logic [ANCHOR_NUM_W-1:0] c_ext;
  logic [ANCHOR_NUM_W-1:0] anchor_num;
  logic [NUM_W-1:0]        mag_ext;
  logic [NUM_W-1:0]        count_num;
  logic [CHG_W-1:0]        cap_eff;

  logic             div_start;
  logic [NUM_W-1:0] div_dividend;
  logic [CHG_W-1:0] div_divisor;
  logic [CNT_W-1:0] div_iters;
  logic [NUM_W-1:0] quo;
  logic             div_done;

  logic [NUM_W:0]   sum_up;
  logic             clamp_lo;
  logic             clamp_hi;
  out_item_t        result;

  assign ge_full = volts >= full_level;
  assign le_empty = volts <= empty_level;
  assign range_ok = full_level > empty_level;
  assign range_v = full_level - empty_level;

  assign c_hi = (volts > full_level) ? full_level : volts;
  assign c_lo = (c_hi < empty_level) ? empty_level : c_hi;
  assign c_off = c_lo - empty_level;
  assign c_ext = {{SOC_W{1'b0}}, c_off};
  // x * 25600 = (x << 14) + (x << 13) + (x << 10)
  assign anchor_num = (c_ext << 14) + (c_ext << 13) + (c_ext << 10);
  assign mag_ext = {{SOC_W{1'b0}}, mag};
  assign count_num = (mag_ext << 14) + (mag_ext << 13) + (mag_ext << 10);
  assign cap_eff = (capacity == '0) ? CHG_W'(1) : capacity;

  assign div_start = cmd.anchor_go | cmd.count_go;
  assign div_dividend = cmd.anchor_go ? {anchor_num, {VOLT_W{1'b0}}} : count_num;
  assign div_divisor = cmd.anchor_go ? {{(CHG_W-VOLT_W){1'b0}}, range_v} : cap_eff;
  assign div_iters = cmd.anchor_go ? ANCHOR_ITERS : COUNT_ITERS;

  ccce_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .iters    (div_iters),
    .quotient (quo),
    .done     (div_done)
  );

  assign status.op_restart = op_q;
  assign status.anchored = anchored;
  assign status.extreme = ge_full | le_empty;
  assign status.div_done = div_done;
  assign status.out_free = !out_valid || out_ready;

  assign sum_up = {{(NUM_W+1-SOC_W){1'b0}}, start_level} + {1'b0, quo};
  assign clamp_lo = quo > {{(NUM_W-SOC_W){1'b0}}, start_level};
  assign clamp_hi = sum_up > {{(NUM_W+1-SOC_W){1'b0}}, SOC_FULL};

  always_comb begin
    result.anchored_now = now_flag;
    if (op_q) begin
      result.soc_level = '0;
      result.source = SRC_FULL;
      result.anchored_now = 1'b0;
    end else if (ge_full) begin
      result.soc_level = SOC_FULL;
      result.source = SRC_FULL;
    end else if (le_empty) begin
      result.soc_level = '0;
      result.source = SRC_EMPTY;
    end else if (!neg) begin
      if (clamp_lo) begin
        result.soc_level = '0;
        result.source = SRC_CLAMPED;
      end else begin
        result.soc_level = start_level - quo[SOC_W-1:0];
        result.source = SRC_COUNTED;
      end
    end else begin
      if (clamp_hi) begin
        result.soc_level = SOC_FULL;
        result.source = SRC_CLAMPED;
      end else begin
        result.soc_level = sum_up[SOC_W-1:0];
        result.source = SRC_COUNTED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full_level <= FULL_RESET;
      empty_level <= EMPTY_RESET;
      capacity <= CAP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FULL:  full_level <= cfg_data[VOLT_W-1:0];
        CFG_EMPTY: empty_level <= cfg_data[VOLT_W-1:0];
        CFG_CAP:   capacity <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_level <= SOC_FULL;
      anchored <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.restart) begin
        anchored <= 1'b0;
      end else if (cmd.anchor_set) begin
        anchored <= 1'b1;
        start_level <= range_ok ? quo[SOC_W-1:0] : '0;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q <= in_data.op;
      volts <= in_data.bus_raw[23:4];
      neg <= in_data.charge_raw[39];
      mag <= in_data.charge_raw[39] ? (~in_data.charge_raw + CHG_W'(1))
                                    : in_data.charge_raw;
      now_flag <= 1'b0;
    end else if (cmd.anchor_set) begin
      now_flag <= 1'b1;
    end
    if (cmd.emit) begin
      out_data <= result;
    end
  end

  `CCCE_ASSERT_NOW(a_emit_free, cmd.emit, !out_valid || out_ready, "item overwrote held result")
  `CCCE_ASSERT_NOW(a_soc_range, out_valid, out_data.soc_level <= SOC_FULL, "soc above full")
  `CCCE_ASSERT_NOW(a_anchor_div, cmd.anchor_set, div_done, "anchor set without quotient")

endmodule

FILE: sv/coulomb_count_charge_estimator_top.sv
// Path, accept to out_valid: restart or an anchored voltage at a limit goes CHECK, EMIT;
// a limit sample that also anchors goes CHECK, ANCHOR, EMIT; a counted sample goes CHECK,
// COUNT, EMIT; a counted sample that also anchors goes CHECK, ANCHOR, COUNT, EMIT.
// A new item is taken only once the last result is emitted; the 1-bit/cycle divider (35 steps
// anchoring, 55 steps counting) sets the pace, and EMIT waits while a held result is not taken.
// Synchronous active-high rst: config registers to reset values, start level 100%, not
// anchored, no result held.
module coulomb_count_charge_estimator_top
  import ccce_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [39:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  ccce_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  ccce_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
